// ----- rtl/detour_bezier_path_generator_unit_macros.svh -----
// Assertion macros used by the checker file.
`ifndef DETOUR_BEZIER_PATH_GENERATOR_UNIT_MACROS_SVH
`define DETOUR_BEZIER_PATH_GENERATOR_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define DBP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define DBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/dbpg_pkg.sv -----
`timescale 1ns / 1ps
package dbpg_pkg;
  localparam int PointsPerCurve = 8;
  localparam int StepMax = PointsPerCurve - 1;
  localparam int IdxW = $clog2(PointsPerCurve);
  localparam int WgtW = 2 * IdxW + 1;
  localparam int DetourMm = 25;
  localparam int SquareMm = 50;
  localparam int CoordW = 13;
  localparam int InW = 9;
  localparam int MmW = 11;
  localparam int NumW = 24;
  localparam int RecipW = 32;
  localparam int Denom = StepMax * StepMax;
  localparam longint RecipFull =
      ((longint'(1) << RecipW) + longint'(2 * Denom) - 1) / longint'(2 * Denom);
  localparam logic [RecipW-1:0] RecipK = RecipW'(RecipFull);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLAN,
    ST_SAMPLE,
    ST_DIVIDE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic signed [MmW-1:0] a;
    logic signed [MmW-1:0] b;
    logic signed [MmW-1:0] c;
  } curve_t;
endpackage

// ----- rtl/dbpg_if.sv -----
`timescale 1ns / 1ps
interface dbpg_in_if;
  logic valid;
  logic ready;
  logic signed [8:0] start_x;
  logic signed [8:0] start_y;
  logic signed [8:0] end_x;
  logic signed [8:0] end_y;
  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface dbpg_out_if;
  logic valid;
  logic ready;
  logic signed [12:0] point_x;
  logic signed [12:0] point_y;
  logic [1:0] curve_number;
  logic [1:0] curve_total;
  logic final_sample;
  modport source (output valid, point_x, point_y, curve_number, curve_total, final_sample,
                  input ready);
  modport sink (input valid, point_x, point_y, curve_number, curve_total, final_sample,
                output ready);
endinterface

// ----- rtl/dbpg_divider.sv -----
`timescale 1ns / 1ps
module dbpg_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dbpg_pkg::NumW-1:0]   num_i,
  output logic                        done_o,
  output logic [dbpg_pkg::NumW-1:0]   quo_o
);
  import dbpg_pkg::*;

  // Division by 2*Denom as a multiplication by its rounded-up reciprocal.
  // The quotient is valid in the cycle after start.
  logic [NumW-1:0] num_q, num_d;
  logic busy_q, busy_d;
  logic [NumW+RecipW-1:0] prod;

  always_comb begin
    num_d = start_i ? num_i : num_q;
    busy_d = start_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
  end

  assign prod = {{RecipW{1'b0}}, num_q} * {{NumW{1'b0}}, RecipK};
  assign done_o = busy_q;
  assign quo_o = prod[NumW+RecipW-1:RecipW];
endmodule

// ----- rtl/detour_bezier_path_generator_unit.sv -----
`timescale 1ns / 1ps
// Each sample word is built per axis by multiplying its three control coefficients
// by their weights on one shared multiplier and accumulating, then a step that
// starts the reciprocal division and one that takes its quotient; the word is
// then offered on the output and held there while the receiver stalls.
// A move has 24 or 16 words; a new move is accepted only after its last word is taken.
// Reset is asynchronous and active low and returns to idle.
module detour_bezier_path_generator_unit (
  input  logic clk_i,
  input  logic rst_ni,
  dbpg_in_if.sink    in_i,
  dbpg_out_if.source out_o
);
  import dbpg_pkg::*;

  state_e state_q, state_d;
  logic signed [MmW-1:0] px_q [5];
  logic signed [MmW-1:0] py_q [5];
  logic signed [MmW-1:0] px_d [5];
  logic signed [MmW-1:0] py_d [5];
  logic [1:0] curves_q, k_q, k_d;
  logic [2:0] k_ix;
  logic [IdxW-1:0] i_q, i_d, u;
  logic [1:0] t_q, t_d;
  logic axis_q, axis_d;
  logic neg_q;
  logic signed [NumW-1:0] acc_q, acc_d, term, nsum;
  logic [NumW-1:0] mag, num;
  logic signed [MmW-1:0] coef;
  logic [WgtW-1:0] wgt;
  logic signed [CoordW-1:0] rx_q, ry_q, res;
  logic div_start, div_done;
  logic [NumW-1:0] div_quo;
  logic signed [MmW-1:0] xi, yi, xf, yf, dx, dy;
  curve_t crv;
  logic last;

  function automatic logic signed [MmW-1:0] snap(logic signed [MmW-1:0] a,
                                                 logic signed [MmW-1:0] b);
    logic signed [MmW-1:0] r;
    r = a;
    if (b > a) r = b - MmW'(DetourMm);
    if (b < a) r = b + MmW'(DetourMm);
    return r;
  endfunction

  assign xi = MmW'(in_i.start_x);
  assign yi = MmW'(in_i.start_y);
  assign xf = MmW'(in_i.end_x);
  assign yf = MmW'(in_i.end_y);
  assign dx = (xi > xf) ? xi - xf : xf - xi;
  assign dy = (yi > yf) ? yi - yf : yf - yi;

  always_comb begin
    for (int j = 0; j < 5; j++) begin
      px_d[j] = px_q[j];
      py_d[j] = py_q[j];
    end
    px_d[0] = xi; py_d[0] = yi; px_d[4] = xf; py_d[4] = yf;
    if (dx > dy) begin
      px_d[1] = xi;
      py_d[1] = (yf < yi) ? yi - MmW'(DetourMm) : yi + MmW'(DetourMm);
      px_d[2] = (xf < xi) ? xf + MmW'(DetourMm) : xf - MmW'(DetourMm);
      py_d[2] = py_d[1];
      px_d[3] = px_d[2];
      py_d[3] = yf;
      if (dy == MmW'(SquareMm) || dy == '0) begin
        if (dy == '0) py_d[1] = (yi > 0) ? yi - MmW'(DetourMm) : yi + MmW'(DetourMm);
        px_d[2] = xf; py_d[2] = py_d[1];
        px_d[3] = xf; py_d[3] = yf;
      end
    end else begin
      px_d[1] = (xf < xi) ? xi - MmW'(DetourMm) : xi + MmW'(DetourMm);
      py_d[1] = yi;
      px_d[2] = px_d[1];
      py_d[2] = (yf < yi) ? yf + MmW'(DetourMm) : yf - MmW'(DetourMm);
      px_d[3] = xf;
      py_d[3] = py_d[2];
      if ((dx < dy && (dx == MmW'(SquareMm) || dx == '0))
          || (dx == MmW'(SquareMm) && dy == MmW'(SquareMm))) begin
        if (dx == '0) px_d[1] = (xi > 0) ? xi - MmW'(DetourMm) : xi + MmW'(DetourMm);
        px_d[2] = px_d[1]; py_d[2] = yf;
        px_d[3] = xf; py_d[3] = yf;
      end
    end
  end

  always_comb begin
    k_ix = {1'b0, k_q};
    if (!axis_q) begin
      crv.a = snap(px_q[k_ix], px_q[k_ix + 3'd1]);
      crv.b = px_q[k_ix + 3'd1];
      crv.c = snap(px_q[k_ix + 3'd2], px_q[k_ix + 3'd1]);
    end else begin
      crv.a = snap(py_q[k_ix], py_q[k_ix + 3'd1]);
      crv.b = py_q[k_ix + 3'd1];
      crv.c = snap(py_q[k_ix + 3'd2], py_q[k_ix + 3'd1]);
    end
    u = IdxW'(StepMax) - i_q;
    case (t_q)
      2'd0: begin
        coef = crv.a;
        wgt = WgtW'(u) * WgtW'(u);
      end
      2'd1: begin
        coef = crv.b;
        wgt = (WgtW'(u) * WgtW'(i_q)) << 1;
      end
      default: begin
        coef = crv.c;
        wgt = WgtW'(i_q) * WgtW'(i_q);
      end
    endcase
    term = NumW'(coef) * $signed(NumW'(wgt));
    acc_d = (t_q == 2'd0) ? term : acc_q + term;
    nsum = acc_q <<< 4;
    mag = nsum[NumW-1] ? NumW'(-nsum) : NumW'(nsum);
    num = (mag << 1) + NumW'(Denom);
  end

  // The rounded quotient is (2*|nsum| + d) / (2*d), with d = Denom.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SAMPLE) acc_q <= acc_d;
    if (state_q == ST_PLAN) neg_q <= nsum[NumW-1];
  end

  dbpg_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_comb begin
    if (neg_q) begin
      res = (div_quo > NumW'(4096)) ? -13'sd4096 : CoordW'(-$signed(div_quo));
    end else begin
      res = (div_quo > NumW'(4095)) ? 13'sd4095 : CoordW'(div_quo);
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_done && !axis_q) rx_q <= res;
    if (div_done && axis_q) ry_q <= res;
    if (state_q == ST_IDLE && in_i.valid) begin
      for (int j = 0; j < 5; j++) begin
        px_q[j] <= px_d[j];
        py_q[j] <= py_d[j];
      end
      curves_q <= ((dx > dy && (dy == MmW'(SquareMm) || dy == '0))
                  || (dx <= dy && ((dx < dy && (dx == MmW'(SquareMm) || dx == '0))
                  || (dx == MmW'(SquareMm) && dy == MmW'(SquareMm))))) ? 2'd2 : 2'd3;
    end
  end

  assign last = (i_q == IdxW'(StepMax)) && (k_q == curves_q - 2'd1);
  assign div_start = (state_q == ST_PLAN);

  always_comb begin
    state_d = state_q;
    k_d = k_q;
    i_d = i_q;
    t_d = t_q;
    axis_d = axis_q;
    case (state_q)
      ST_IDLE: begin
        k_d = '0; i_d = '0; t_d = '0; axis_d = 1'b0;
        if (in_i.valid) begin
          state_d = (dx == '0 && dy == '0) ? ST_IDLE : ST_SAMPLE;
        end
      end
      ST_SAMPLE: begin
        if (t_q == 2'd2) begin
          t_d = '0;
          state_d = ST_PLAN;
        end else begin
          t_d = t_q + 2'd1;
        end
      end
      ST_PLAN: state_d = ST_DIVIDE;
      ST_DIVIDE: begin
        if (div_done) begin
          if (!axis_q) begin
            axis_d = 1'b1;
            state_d = ST_SAMPLE;
          end else begin
            axis_d = 1'b0;
            state_d = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (out_o.ready) begin
          if (last) begin
            state_d = ST_IDLE;
          end else if (i_q == IdxW'(StepMax)) begin
            i_d = '0; k_d = k_q + 2'd1; state_d = ST_SAMPLE;
          end else begin
            i_d = i_q + IdxW'(1); state_d = ST_SAMPLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = (state_q == ST_IDLE);
    out_o.valid = (state_q == ST_OUT);
    out_o.point_x = rx_q;
    out_o.point_y = ry_q;
    out_o.curve_number = k_q;
    out_o.curve_total = curves_q;
    out_o.final_sample = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q <= '0;
      i_q <= '0;
      t_q <= '0;
      axis_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q <= k_d;
      i_q <= i_d;
      t_q <= t_d;
      axis_q <= axis_d;
    end
  end
endmodule

// ----- rtl/dbpg_checker.sv -----
`timescale 1ns / 1ps
`include "detour_bezier_path_generator_unit_macros.svh"
module dbpg_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic final_i,
  input logic [1:0] curve_number_i,
  input logic [1:0] curve_total_i
);
  `DBP_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, out_valid_i, !in_ready_i)
  `DBP_ASSERT_IMP(a_curve_range, clk_i, rst_ni, out_valid_i, curve_number_i < curve_total_i)
  `DBP_ASSERT_IMP(a_final_curve, clk_i, rst_ni, out_valid_i && final_i,
                  curve_number_i == curve_total_i - 2'd1)
  `DBP_ASSERT_NEXT(a_final_frees, clk_i, rst_ni, out_valid_i && out_ready_i && final_i,
                   in_ready_i)
  `DBP_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
endmodule

bind detour_bezier_path_generator_unit dbpg_checker u_chk (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_i.valid),
  .in_ready_i(in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .final_i(out_o.final_sample),
  .curve_number_i(out_o.curve_number),
  .curve_total_i(out_o.curve_total)
);
